[sv/ckse_pkg.sv]
package ckse_pkg;

   localparam longint unsigned MaxContigLength = 64'd16777216;
   localparam longint unsigned MaxContigs      = 64'd65536;

   localparam int unsigned BASE_W   = 8;
   localparam int unsigned KSIZE_W  = 6;
   localparam int unsigned WORD_W   = 64;
   localparam int unsigned CONTIG_W = 16;
   localparam int unsigned POS_W    = 24;
   localparam int unsigned CSR_AW   = 3;
   localparam int unsigned CSR_DW   = 32;

   localparam longint unsigned PosLimitWide =
      (MaxContigLength - 64'd1 > 64'hFF_FFFF) ? 64'hFF_FFFF : MaxContigLength - 64'd1;
   localparam longint unsigned ContigLimitWide =
      (MaxContigs - 64'd1 > 64'hFFFF) ? 64'hFFFF : MaxContigs - 64'd1;

   localparam logic [POS_W-1:0]    POS_LIMIT    = PosLimitWide[POS_W-1:0];
   localparam logic [CONTIG_W-1:0] CONTIG_LIMIT = ContigLimitWide[CONTIG_W-1:0];

   localparam logic [KSIZE_W-1:0] KSIZE_RESET = 6'd31;
   localparam logic [KSIZE_W-1:0] KSIZE_MAX   = 6'd32;
   localparam logic [KSIZE_W-1:0] KSIZE_MIN   = 6'd1;

   // register index lives at paddr[2]
   localparam logic REG_KMER_SIZE = 1'b0;

   localparam logic [BASE_W-1:0] CHAR_A = 8'h41;
   localparam logic [BASE_W-1:0] CHAR_C = 8'h43;
   localparam logic [BASE_W-1:0] CHAR_G = 8'h47;
   localparam logic [BASE_W-1:0] CHAR_T = 8'h54;

   typedef struct packed {
      logic       valid;
      logic [1:0] code;
   } base_type;

   function automatic base_type decode_base(input logic [BASE_W-1:0] ch);
      base_type r;
      r.valid = 1'b1;
      r.code  = 2'd0;
      case (ch)
         CHAR_A:  r.code = 2'd0;
         CHAR_C:  r.code = 2'd1;
         CHAR_G:  r.code = 2'd2;
         CHAR_T:  r.code = 2'd3;
         default: r.valid = 1'b0;
      endcase
      return r;
   endfunction

endpackage

[sv/canonical_kmer_stream_extractor_core.sv]
// Canonical k-mer extractor: one ASCII character per item, req_last_of_contig
// on the final character of each contig. Each A/C/G/T base, once the current
// run holds kmer_size bases, yields one item carrying the smaller of the forward
// and reverse-complement 2-bit k-mers (A=0 C=1 G=2 T=3), a strand flag, the
// contig index and the start offset; any other character restarts the run.
// Throughput is one item per clock when the output is not stalled; an accepted
// item goes to the input register, then through the single shift, mask and
// 64-bit compare stage into the result register, which drives rsp_valid. kmer_size
// (register 0, reset 31, 0 acts as 1, above 32 acts as 32) must be written only
// while the block is idle; a write restarts the run but keeps position and
// contig count. Position and contig counters saturate.
module canonical_kmer_stream_extractor_core
   import ckse_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BASE_W-1:0]   req_base_char,
   input  logic                req_last_of_contig,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORD_W-1:0]   rsp_canonical_kmer,
   output logic                rsp_forward_strand,
   output logic [CONTIG_W-1:0] rsp_contig_number,
   output logic [POS_W-1:0]    rsp_kmer_start,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   logic [KSIZE_W-1:0]  ksize_ff;
   logic                in_valid_ff;
   logic [BASE_W-1:0]   in_char_ff;
   logic                in_last_ff;
   logic [WORD_W-1:0]   fwd_ff, fwd_in;
   logic [WORD_W-1:0]   rc_ff, rc_in;
   logic [KSIZE_W-1:0]  run_ff, run_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CONTIG_W-1:0] contig_ff, contig_in;
   logic                rsp_valid_ff;
   logic [WORD_W-1:0]   rsp_kmer_ff;
   logic                rsp_fwd_ff;
   logic [CONTIG_W-1:0] rsp_contig_ff;
   logic [POS_W-1:0]    rsp_start_ff;

   logic                csr_wr;
   logic                advance;
   logic                emit;
   logic [KSIZE_W-1:0]  k_eff;
   logic [KSIZE_W-1:0]  km1;
   logic [6:0]          mask_sh;
   logic [WORD_W-1:0]   mask;
   logic [5:0]          rc_sh;
   logic [KSIZE_W-1:0]  run_inc;
   logic [WORD_W-1:0]   fwd_shift, rc_shift;
   logic                fwd_less;
   logic [POS_W-1:0]    start_val;
   base_type            base;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & (csr_paddr[2] == REG_KMER_SIZE);
   assign csr_prdata = (csr_paddr[2] == REG_KMER_SIZE) ?
                       {{(CSR_DW-KSIZE_W){1'b0}}, ksize_ff} : '0;

   assign advance   = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   always_comb begin
      if (ksize_ff == '0) begin
         k_eff = KSIZE_MIN;
      end else if (ksize_ff > KSIZE_MAX) begin
         k_eff = KSIZE_MAX;
      end else begin
         k_eff = ksize_ff;
      end
   end

   assign km1     = k_eff - KSIZE_MIN;
   assign mask_sh = 7'd64 - {k_eff, 1'b0};
   assign mask    = {WORD_W{1'b1}} >> mask_sh;
   assign rc_sh   = {km1[4:0], 1'b0};
   assign base    = decode_base(in_char_ff);

   always_comb begin
      fwd_shift = {fwd_ff[WORD_W-3:0], base.code} & mask;
      rc_shift  = ((rc_ff >> 2) | ({{(WORD_W-2){1'b0}}, 2'd3 - base.code} << rc_sh)) & mask;
      run_inc   = (run_ff < k_eff) ? run_ff + 6'd1 : run_ff;
      emit      = base.valid & (run_inc >= k_eff);
      fwd_less  = fwd_shift < rc_shift;
      start_val = (pos_ff >= {{(POS_W-KSIZE_W){1'b0}}, km1}) ?
                  pos_ff - {{(POS_W-KSIZE_W){1'b0}}, km1} : '0;

      fwd_in    = fwd_ff;
      rc_in     = rc_ff;
      run_in    = run_ff;
      pos_in    = pos_ff;
      contig_in = contig_ff;

      if (csr_wr) begin
         fwd_in = '0;
         rc_in  = '0;
         run_in = '0;
      end else if (advance) begin
         if (base.valid) begin
            fwd_in = fwd_shift;
            rc_in  = rc_shift;
            run_in = run_inc;
         end else begin
            fwd_in = '0;
            rc_in  = '0;
            run_in = '0;
         end
         if (in_last_ff) begin
            fwd_in = '0;
            rc_in  = '0;
            run_in = '0;
            pos_in = '0;
            if (contig_ff < CONTIG_LIMIT) begin
               contig_in = contig_ff + 16'd1;
            end
         end else if (pos_ff < POS_LIMIT) begin
            pos_in = pos_ff + 24'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ksize_ff     <= KSIZE_RESET;
         in_valid_ff  <= 1'b0;
         fwd_ff       <= '0;
         rc_ff        <= '0;
         run_ff       <= '0;
         pos_ff       <= '0;
         contig_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            ksize_ff <= csr_pwdata[KSIZE_W-1:0];
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         fwd_ff    <= fwd_in;
         rc_ff     <= rc_in;
         run_ff    <= run_in;
         pos_ff    <= pos_in;
         contig_ff <= contig_in;
         if (advance) begin
            rsp_valid_ff <= emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready & req_valid) begin
         in_char_ff <= req_base_char;
         in_last_ff <= req_last_of_contig;
      end
      if (advance & emit) begin
         rsp_kmer_ff   <= fwd_less ? fwd_shift : rc_shift;
         rsp_fwd_ff    <= fwd_less;
         rsp_contig_ff <= contig_ff;
         rsp_start_ff  <= start_val;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_canonical_kmer = rsp_kmer_ff;
   assign rsp_forward_strand = rsp_fwd_ff;
   assign rsp_contig_number  = rsp_contig_ff;
   assign rsp_kmer_start     = rsp_start_ff;

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      run_ff <= k_eff || $past(csr_wr))
      else $error("run length beyond k");

   a_cfg_clears_run: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> (run_ff == '0 && fwd_ff == '0 && rc_ff == '0))
      else $error("config write did not clear run");

   a_last_clears_pos: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff && !csr_wr) |=> (pos_ff == '0 && run_ff == '0))
      else $error("contig end did not clear position");

   a_emit_full_run: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && !in_last_ff && !csr_wr) |=> (rsp_valid_ff && run_ff == k_eff))
      else $error("item issued without a full run");

endmodule
